### sv/amcs_pkg.sv
// Shared types, codes and command/reply ROMs for the AT command modem sequencer.
// Used by every module of the block; has no dependencies of its own.
package amcs_pkg;

    // ROM geometry: longest command and longest expected reply, in bytes
    localparam int CMD_MAX   = 46;
    localparam int REPLY_MAX = 14;

    typedef logic [5:0] cmd_idx_t;
    typedef logic [3:0] reply_idx_t;
    typedef logic [2:0] slot_t;

    // command slots
    localparam slot_t SLOT_PROBE   = 3'd0;
    localparam slot_t SLOT_MODE    = 3'd1;
    localparam slot_t SLOT_RFCFG   = 3'd2;
    localparam slot_t SLOT_RXSTART = 3'd3;
    localparam slot_t SLOT_STOP    = 3'd4;
    localparam slot_t SLOT_RESET   = 3'd5;

    // input command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // reply status codes
    localparam logic [1:0] RS_NONE    = 2'd0;
    localparam logic [1:0] RS_DONE    = 2'd1;
    localparam logic [1:0] RS_TIMEOUT = 2'd2;
    localparam logic [1:0] RS_ERROR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_INACTIVE = 2'd1;
    localparam logic [1:0] REG_RETRY    = 2'd2;
    localparam logic [1:0] REG_ECHO     = 2'd3;

    localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;

    // sequence stages, one-hot
    typedef enum logic [14:0] {
        ST_IDLE      = 15'b000000000000001,
        ST_PROBE     = 15'b000000000000010,
        ST_PROBE_R   = 15'b000000000000100,
        ST_MODE      = 15'b000000000001000,
        ST_MODE_R    = 15'b000000000010000,
        ST_RFCFG     = 15'b000000000100000,
        ST_RFCFG_R   = 15'b000000001000000,
        ST_RXSTART   = 15'b000000010000000,
        ST_RXSTART_R = 15'b000000100000000,
        ST_RXWAIT    = 15'b000001000000000,
        ST_STOP      = 15'b000010000000000,
        ST_STOP_R    = 15'b000100000000000,
        ST_RESET     = 15'b001000000000000,
        ST_RESET_R   = 15'b010000000000000,
        ST_CLEANUP   = 15'b100000000000000
    } stage_t;

    // one unit of work handed from front to back
    typedef struct packed {
        logic       burst;      // emit the command text of slot
        slot_t      slot;
        logic       echo;       // console_valid of the result(s)
        logic [7:0] byte_val;   // console byte of a single result
        logic [1:0] status;
        logic [3:0] stage_code;
        logic       active;
    } job_t;

    typedef struct packed {
        logic [15:0] reply_timeout_ms;
        logic [22:0] inactive_limit_ms;
        logic [2:0]  retry_limit;
        logic        debug_echo;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // command text, left aligned and zero padded
    localparam logic [CMD_MAX*8-1:0] CMD_ROM_0 =
        {"AT", CHAR_CR, CHAR_LF, {42{8'h00}}};
    localparam logic [CMD_MAX*8-1:0] CMD_ROM_1 =
        {"AT+MODE=TEST", CHAR_CR, CHAR_LF, {32{8'h00}}};
    localparam logic [CMD_MAX*8-1:0] CMD_ROM_2 =
        {"AT+TEST=RFCFG,868,SF7,125,8,8,14,OFF,OFF,OFF", CHAR_CR, CHAR_LF};
    localparam logic [CMD_MAX*8-1:0] CMD_ROM_3 =
        {"AT+TEST=RXLRPKT", CHAR_CR, CHAR_LF, {29{8'h00}}};
    localparam logic [CMD_MAX*8-1:0] CMD_ROM_4 =
        {"AT+TEST=STOP", CHAR_CR, CHAR_LF, {32{8'h00}}};
    localparam logic [CMD_MAX*8-1:0] CMD_ROM_5 =
        {"AT+RESET", CHAR_CR, CHAR_LF, {36{8'h00}}};

    // expected reply prefixes
    localparam logic [REPLY_MAX*8-1:0] REPLY_ROM_0 = {"+AT: OK", {7{8'h00}}};
    localparam logic [REPLY_MAX*8-1:0] REPLY_ROM_1 = {"+MODE: TEST", {3{8'h00}}};
    localparam logic [REPLY_MAX*8-1:0] REPLY_ROM_2 = {"+TEST: RFCFG", {2{8'h00}}};
    localparam logic [REPLY_MAX*8-1:0] REPLY_ROM_3 = {"+TEST: RXLRPKT"};
    localparam logic [REPLY_MAX*8-1:0] REPLY_ROM_4 = {"+TEST: STOP", {3{8'h00}}};
    localparam logic [REPLY_MAX*8-1:0] REPLY_ROM_5 = {"+RESET: OK", {4{8'h00}}};

    function automatic cmd_idx_t cmd_len(slot_t s);
        case (s)
            SLOT_PROBE:   cmd_len = 6'd4;
            SLOT_MODE:    cmd_len = 6'd14;
            SLOT_RFCFG:   cmd_len = 6'd46;
            SLOT_RXSTART: cmd_len = 6'd17;
            SLOT_STOP:    cmd_len = 6'd14;
            SLOT_RESET:   cmd_len = 6'd10;
            default:      cmd_len = 6'd1;
        endcase
    endfunction

    function automatic logic [7:0] cmd_byte(slot_t s, cmd_idx_t idx);
        logic [CMD_MAX*8-1:0] row;
        case (s)
            SLOT_PROBE:   row = CMD_ROM_0;
            SLOT_MODE:    row = CMD_ROM_1;
            SLOT_RFCFG:   row = CMD_ROM_2;
            SLOT_RXSTART: row = CMD_ROM_3;
            SLOT_STOP:    row = CMD_ROM_4;
            SLOT_RESET:   row = CMD_ROM_5;
            default:      row = '0;
        endcase
        if (int'(idx) < CMD_MAX)
            cmd_byte = row[8*(CMD_MAX-1-int'(idx)) +: 8];
        else
            cmd_byte = 8'h00;
    endfunction

    function automatic reply_idx_t reply_len(slot_t s);
        case (s)
            SLOT_PROBE:   reply_len = 4'd7;
            SLOT_MODE:    reply_len = 4'd11;
            SLOT_RFCFG:   reply_len = 4'd12;
            SLOT_RXSTART: reply_len = 4'd14;
            SLOT_STOP:    reply_len = 4'd11;
            SLOT_RESET:   reply_len = 4'd10;
            default:      reply_len = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] reply_byte(slot_t s, reply_idx_t idx);
        logic [REPLY_MAX*8-1:0] row;
        case (s)
            SLOT_PROBE:   row = REPLY_ROM_0;
            SLOT_MODE:    row = REPLY_ROM_1;
            SLOT_RFCFG:   row = REPLY_ROM_2;
            SLOT_RXSTART: row = REPLY_ROM_3;
            SLOT_STOP:    row = REPLY_ROM_4;
            SLOT_RESET:   row = REPLY_ROM_5;
            default:      row = '0;
        endcase
        if (int'(idx) < REPLY_MAX)
            reply_byte = row[8*(REPLY_MAX-1-int'(idx)) +: 8];
        else
            reply_byte = 8'h00;
    endfunction

    // stage number as seen on the stage output
    function automatic logic [3:0] stage_code(stage_t s);
        case (s)
            ST_IDLE:      stage_code = 4'd0;
            ST_PROBE:     stage_code = 4'd1;
            ST_PROBE_R:   stage_code = 4'd2;
            ST_MODE:      stage_code = 4'd3;
            ST_MODE_R:    stage_code = 4'd4;
            ST_RFCFG:     stage_code = 4'd5;
            ST_RFCFG_R:   stage_code = 4'd6;
            ST_RXSTART:   stage_code = 4'd7;
            ST_RXSTART_R: stage_code = 4'd8;
            ST_RXWAIT:    stage_code = 4'd9;
            ST_STOP:      stage_code = 4'd10;
            ST_STOP_R:    stage_code = 4'd11;
            ST_RESET:     stage_code = 4'd12;
            ST_RESET_R:   stage_code = 4'd13;
            ST_CLEANUP:   stage_code = 4'd14;
            default:      stage_code = 4'd0;
        endcase
    endfunction

    function automatic logic is_send(stage_t s);
        case (s)
            ST_PROBE, ST_MODE, ST_RFCFG, ST_RXSTART, ST_STOP, ST_RESET:
                is_send = 1'b1;
            default:
                is_send = 1'b0;
        endcase
    endfunction

    function automatic logic is_reply(stage_t s);
        case (s)
            ST_PROBE_R, ST_MODE_R, ST_RFCFG_R, ST_RXSTART_R, ST_STOP_R, ST_RESET_R:
                is_reply = 1'b1;
            default:
                is_reply = 1'b0;
        endcase
    endfunction

    function automatic slot_t slot_of(stage_t s);
        case (s)
            ST_PROBE, ST_PROBE_R:     slot_of = SLOT_PROBE;
            ST_MODE, ST_MODE_R:       slot_of = SLOT_MODE;
            ST_RFCFG, ST_RFCFG_R:     slot_of = SLOT_RFCFG;
            ST_RXSTART, ST_RXSTART_R: slot_of = SLOT_RXSTART;
            ST_STOP, ST_STOP_R:       slot_of = SLOT_STOP;
            ST_RESET, ST_RESET_R:     slot_of = SLOT_RESET;
            default:                  slot_of = SLOT_PROBE;
        endcase
    endfunction

    // send stage -> its reply stage
    function automatic stage_t reply_of(slot_t s);
        case (s)
            SLOT_PROBE:   reply_of = ST_PROBE_R;
            SLOT_MODE:    reply_of = ST_MODE_R;
            SLOT_RFCFG:   reply_of = ST_RFCFG_R;
            SLOT_RXSTART: reply_of = ST_RXSTART_R;
            SLOT_STOP:    reply_of = ST_STOP_R;
            SLOT_RESET:   reply_of = ST_RESET_R;
            default:      reply_of = ST_IDLE;
        endcase
    endfunction

    // reply stage -> its send stage (resend)
    function automatic stage_t send_of(slot_t s);
        case (s)
            SLOT_PROBE:   send_of = ST_PROBE;
            SLOT_MODE:    send_of = ST_MODE;
            SLOT_RFCFG:   send_of = ST_RFCFG;
            SLOT_RXSTART: send_of = ST_RXSTART;
            SLOT_STOP:    send_of = ST_STOP;
            SLOT_RESET:   send_of = ST_RESET;
            default:      send_of = ST_IDLE;
        endcase
    endfunction

    // where a good reply leads
    function automatic stage_t done_next(slot_t s);
        case (s)
            SLOT_PROBE:   done_next = ST_MODE;
            SLOT_MODE:    done_next = ST_RFCFG;
            SLOT_RFCFG:   done_next = ST_RXSTART;
            SLOT_RXSTART: done_next = ST_RXWAIT;
            SLOT_STOP:    done_next = ST_RESET;
            SLOT_RESET:   done_next = ST_PROBE;
            default:      done_next = ST_IDLE;
        endcase
    endfunction

endpackage

### sv/amcs_front.sv
// Front end: accepts input beats, runs the sequence stage machine and the reply
// matcher, and pushes one job per beat into the queue. Depends on amcs_pkg.
module amcs_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  amcs_pkg::cfg_t        cfg,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            command,
    input  logic [7:0]            rx_byte,
    input  amcs_pkg::q_status_t   q_status,
    output logic                  push,
    output amcs_pkg::job_t        job
);

    amcs_pkg::stage_t     stage_reg, stage_next;
    logic [2:0]           retries_reg, retries_next;
    logic [23:0]          elapsed_reg, elapsed_next;
    amcs_pkg::reply_idx_t count_reg, count_next;
    logic                 match_reg, match_next;
    logic                 nl_reg, nl_next;

    logic                 accept;
    logic [23:0]          elapsed_sat;
    amcs_pkg::slot_t      slot;
    amcs_pkg::reply_idx_t exp_len;
    logic [7:0]           exp_byte;
    logic [1:0]           status;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;
    assign push       = accept;

    // shared lookups for the current stage
    assign slot        = amcs_pkg::slot_of(stage_reg);
    assign exp_len     = amcs_pkg::reply_len(slot);
    assign exp_byte    = amcs_pkg::reply_byte(slot, count_reg);
    assign elapsed_sat = (elapsed_reg == amcs_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                : elapsed_reg + 24'd1;

    // reply verdict on a tick
    always_comb
    begin
        if (!nl_reg && (elapsed_sat < {8'd0, cfg.reply_timeout_ms}))
            status = amcs_pkg::RS_NONE;
        else if (!nl_reg)
            status = amcs_pkg::RS_TIMEOUT;
        else if ((count_reg != exp_len) || !match_reg)
            status = amcs_pkg::RS_ERROR;
        else
            status = amcs_pkg::RS_DONE;
    end

    // stage machine and job build
    always_comb
    begin
        stage_next   = stage_reg;
        retries_next = retries_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        match_next   = match_reg;
        nl_next      = nl_reg;

        job          = '0;
        job.slot     = slot;

        if (accept)
        begin
            case (command)
                amcs_pkg::CMD_START:
                begin
                    stage_next   = amcs_pkg::ST_PROBE;
                    retries_next = cfg.retry_limit;
                end
                amcs_pkg::CMD_RX:
                begin
                    if (stage_reg == amcs_pkg::ST_RXWAIT)
                    begin
                        elapsed_next = '0;
                        job.echo     = 1'b1;
                        job.byte_val = rx_byte;
                    end
                    else if (amcs_pkg::is_reply(stage_reg) && !nl_reg)
                    begin
                        if (count_reg < exp_len)
                        begin
                            if (exp_byte != rx_byte)
                                match_next = 1'b0;
                            count_next = count_reg + 4'd1;
                        end
                        if (rx_byte == amcs_pkg::CHAR_LF)
                            nl_next = 1'b1;
                        job.echo     = cfg.debug_echo;
                        job.byte_val = rx_byte;
                    end
                end
                amcs_pkg::CMD_TICK:
                begin
                    elapsed_next = elapsed_sat;
                    if (amcs_pkg::is_send(stage_reg))
                    begin
                        job.burst    = 1'b1;
                        job.echo     = cfg.debug_echo;
                        elapsed_next = '0;
                        count_next   = '0;
                        match_next   = 1'b1;
                        nl_next      = 1'b0;
                        stage_next   = amcs_pkg::reply_of(slot);
                    end
                    else if (amcs_pkg::is_reply(stage_reg))
                    begin
                        job.status = status;
                        if (status == amcs_pkg::RS_DONE)
                        begin
                            stage_next   = amcs_pkg::done_next(slot);
                            retries_next = cfg.retry_limit;
                        end
                        else if (status != amcs_pkg::RS_NONE)
                        begin
                            if (retries_reg != 3'd0)
                            begin
                                stage_next   = amcs_pkg::send_of(slot);
                                retries_next = retries_reg - 3'd1;
                            end
                            else
                            begin
                                stage_next = amcs_pkg::ST_CLEANUP;
                            end
                        end
                    end
                    else if ((stage_reg == amcs_pkg::ST_RXWAIT) &&
                             (elapsed_sat > {1'b0, cfg.inactive_limit_ms}))
                    begin
                        stage_next = amcs_pkg::ST_STOP;
                    end
                    else if (stage_reg == amcs_pkg::ST_CLEANUP)
                    begin
                        stage_next = amcs_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    // unknown command: no state change, empty result
                end
            endcase
        end

        job.stage_code = amcs_pkg::stage_code(stage_next);
        job.active     = (stage_next != amcs_pkg::ST_IDLE);
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= amcs_pkg::ST_PROBE;
            retries_reg <= 3'd3;
            elapsed_reg <= '0;
            count_reg   <= '0;
            match_reg   <= 1'b1;
            nl_reg      <= 1'b0;
        end
        else
        begin
            stage_reg   <= stage_next;
            retries_reg <= retries_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            match_reg   <= match_next;
            nl_reg      <= nl_next;
        end
    end

endmodule

### sv/amcs_queue.sv
// Short job queue between front and back; each side stalls on its own.
// Register-based FIFO of amcs_pkg::job_t entries. Depends on amcs_pkg.
module amcs_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  amcs_pkg::job_t        push_job,
    input  logic                  pop,
    output amcs_pkg::job_t        head_job,
    output amcs_pkg::q_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    amcs_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### sv/amcs_back.sv
// Back end: expands queued jobs into result beats, stepping through the
// command ROM for sends, into a registered output stage. Depends on amcs_pkg.
module amcs_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  amcs_pkg::job_t        head_job,
    input  amcs_pkg::q_status_t   q_status,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  modem_valid,
    output logic [7:0]            modem_byte,
    output logic                  console_valid,
    output logic [7:0]            console_byte,
    output logic [1:0]            reply_status,
    output logic [3:0]            stage,
    output logic                  active,
    output logic                  last
);

    amcs_pkg::cmd_idx_t idx_reg, idx_next;
    logic               valid_reg;
    logic               mv_reg, cv_reg, active_reg, last_reg;
    logic [7:0]         mb_reg, cb_reg;
    logic [1:0]         rs_reg;
    logic [3:0]         stage_reg;

    logic               load;
    logic               emit;
    logic               cur_last;
    logic [7:0]         cur_char;

    // output register frees up when empty or taken
    assign load     = !valid_reg || !result_stall;
    assign emit     = load && !q_status.empty;
    assign cur_char = amcs_pkg::cmd_byte(head_job.slot, idx_reg);
    assign cur_last = !head_job.burst ||
                      (idx_reg == (amcs_pkg::cmd_len(head_job.slot) - 6'd1));
    assign pop      = emit && cur_last;

    // byte counter across a send burst
    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = cur_last ? '0 : idx_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= !q_status.empty;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            mv_reg     <= head_job.burst;
            mb_reg     <= head_job.burst ? cur_char : 8'h00;
            cv_reg     <= head_job.echo;
            if (!head_job.echo)
                cb_reg <= 8'h00;
            else
                cb_reg <= head_job.burst ? cur_char : head_job.byte_val;
            rs_reg     <= head_job.status;
            stage_reg  <= head_job.stage_code;
            active_reg <= head_job.active;
            last_reg   <= cur_last;
        end
    end

    assign result_valid  = valid_reg;
    assign modem_valid   = mv_reg;
    assign modem_byte    = mb_reg;
    assign console_valid = cv_reg;
    assign console_byte  = cb_reg;
    assign reply_status  = rs_reg;
    assign stage         = stage_reg;
    assign active        = active_reg;
    assign last          = last_reg;

endmodule

### sv/at_command_modem_sequencer.sv
// AT command modem sequencer: front stage machine, job queue, result expander.
// An item's first result passes through its queue entry and then the output register.
// Throughput: one input beat per cycle while the queue is not full; results leave at one
// per cycle unless result_stall holds them, so a send tick (up to 46 command bytes) holds the
// output for one result per byte and the input stalls once QUEUE_DEPTH - 1 jobs wait behind it.
// Reset: config registers take their defaults, stage is probe, queue empty.
module at_command_modem_sequencer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        modem_valid,
    output logic [7:0]  modem_byte,
    output logic        console_valid,
    output logic [7:0]  console_byte,
    output logic [1:0]  reply_status,
    output logic [3:0]  stage,
    output logic        active,
    output logic        last,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    amcs_pkg::cfg_t      cfg_reg;
    amcs_pkg::q_status_t q_status;
    amcs_pkg::job_t      push_job;
    amcs_pkg::job_t      head_job;
    logic                push;
    logic                pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reply_timeout_ms  <= 16'd2000;
            cfg_reg.inactive_limit_ms <= 23'd5400000;
            cfg_reg.retry_limit       <= 3'd3;
            cfg_reg.debug_echo        <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                amcs_pkg::REG_TIMEOUT:  cfg_reg.reply_timeout_ms  <= cfg_data[15:0];
                amcs_pkg::REG_INACTIVE: cfg_reg.inactive_limit_ms <= cfg_data;
                amcs_pkg::REG_RETRY:    cfg_reg.retry_limit       <= cfg_data[2:0];
                amcs_pkg::REG_ECHO:     cfg_reg.debug_echo        <= cfg_data[0];
                default:                cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    amcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .rx_byte    (rx_byte),
        .q_status   (q_status),
        .push       (push),
        .job        (push_job)
    );

    amcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    amcs_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_status      (q_status),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .modem_valid   (modem_valid),
        .modem_byte    (modem_byte),
        .console_valid (console_valid),
        .console_byte  (console_byte),
        .reply_status  (reply_status),
        .stage         (stage),
        .active        (active),
        .last          (last)
    );

    // an accepted beat leaves a job in the queue
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> !q_status.empty)
        else $error("accepted beat did not reach the queue");

    // a taken command byte that is not the last is followed by the next one
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && modem_valid && !last && !result_stall
        |=> result_valid && modem_valid)
        else $error("command burst broke off");

    // a reply verdict is a lone, silent result
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (reply_status != amcs_pkg::RS_NONE)
        |-> !modem_valid && !console_valid && last)
        else $error("reply status rode on a data beat");

endmodule

### verif/amcs_tb_pkg.sv
// Scoreboard for the AT command modem sequencer: result beat type, stage numbers,
// command and reply text, and a class that predicts and checks result beats.
// Depends on amcs_pkg for command, status, slot, register and character codes.
package amcs_tb_pkg;
    import amcs_pkg::*;

    // command code the block does not know
    localparam logic [1:0] CMD_NONE = 2'd3;

    // stage numbers as seen on the stage output
    localparam logic [3:0] STG_IDLE      = 4'd0;
    localparam logic [3:0] STG_PROBE     = 4'd1;
    localparam logic [3:0] STG_PROBE_R   = 4'd2;
    localparam logic [3:0] STG_MODE      = 4'd3;
    localparam logic [3:0] STG_MODE_R    = 4'd4;
    localparam logic [3:0] STG_RFCFG     = 4'd5;
    localparam logic [3:0] STG_RFCFG_R   = 4'd6;
    localparam logic [3:0] STG_RXSTART   = 4'd7;
    localparam logic [3:0] STG_RXSTART_R = 4'd8;
    localparam logic [3:0] STG_RXWAIT    = 4'd9;
    localparam logic [3:0] STG_STOP      = 4'd10;
    localparam logic [3:0] STG_STOP_R    = 4'd11;
    localparam logic [3:0] STG_RESET     = 4'd12;
    localparam logic [3:0] STG_RESET_R   = 4'd13;
    localparam logic [3:0] STG_CLEANUP   = 4'd14;
    localparam logic [3:0] STG_INVALID   = 4'd15;

    // one result beat, fields in port order
    typedef struct packed {
        logic       modem_valid;
        logic [7:0] modem_byte;
        logic       console_valid;
        logic [7:0] console_byte;
        logic [1:0] reply_status;
        logic [3:0] stage;
        logic       active;
        logic       last;
    } modem_result_t;

    function automatic slot_t slot_for(logic [3:0] st);
        case (st)
            STG_MODE, STG_MODE_R:       slot_for = SLOT_MODE;
            STG_RFCFG, STG_RFCFG_R:     slot_for = SLOT_RFCFG;
            STG_RXSTART, STG_RXSTART_R: slot_for = SLOT_RXSTART;
            STG_STOP, STG_STOP_R:       slot_for = SLOT_STOP;
            STG_RESET, STG_RESET_R:     slot_for = SLOT_RESET;
            default:                    slot_for = SLOT_PROBE;
        endcase
    endfunction

    function automatic bit sends_text(logic [3:0] st);
        case (st)
            STG_PROBE, STG_MODE, STG_RFCFG, STG_RXSTART, STG_STOP, STG_RESET:
                sends_text = 1'b1;
            default:
                sends_text = 1'b0;
        endcase
    endfunction

    function automatic bit awaits_reply(logic [3:0] st);
        case (st)
            STG_PROBE_R, STG_MODE_R, STG_RFCFG_R, STG_RXSTART_R, STG_STOP_R, STG_RESET_R:
                awaits_reply = 1'b1;
            default:
                awaits_reply = 1'b0;
        endcase
    endfunction

    // command text without the trailing CR LF
    function automatic string command_body(slot_t s);
        case (s)
            SLOT_MODE:    command_body = "AT+MODE=TEST";
            SLOT_RFCFG:   command_body = "AT+TEST=RFCFG,868,SF7,125,8,8,14,OFF,OFF,OFF";
            SLOT_RXSTART: command_body = "AT+TEST=RXLRPKT";
            SLOT_STOP:    command_body = "AT+TEST=STOP";
            SLOT_RESET:   command_body = "AT+RESET";
            default:      command_body = "AT";
        endcase
    endfunction

    function automatic string reply_text(slot_t s);
        case (s)
            SLOT_MODE:    reply_text = "+MODE: TEST";
            SLOT_RFCFG:   reply_text = "+TEST: RFCFG";
            SLOT_RXSTART: reply_text = "+TEST: RXLRPKT";
            SLOT_STOP:    reply_text = "+TEST: STOP";
            SLOT_RESET:   reply_text = "+RESET: OK";
            default:      reply_text = "+AT: OK";
        endcase
    endfunction

    // stage that follows a good reply
    function automatic logic [3:0] after_done(slot_t s);
        case (s)
            SLOT_MODE:    after_done = STG_RFCFG;
            SLOT_RFCFG:   after_done = STG_RXSTART;
            SLOT_RXSTART: after_done = STG_RXWAIT;
            SLOT_STOP:    after_done = STG_RESET;
            SLOT_RESET:   after_done = STG_PROBE;
            default:      after_done = STG_MODE;
        endcase
    endfunction

    class modem_scoreboard;
        // sequencer state
        logic [3:0]  stage_q;
        logic [2:0]  retries_q;
        logic [23:0] elapsed_q;
        logic [3:0]  reply_cnt_q;
        logic        reply_ok_q;
        logic        newline_q;
        // register copies
        logic [15:0] timeout_ms;
        logic [22:0] inactive_ms;
        logic [2:0]  retry_max;
        logic        echo_on;

        modem_result_t expected_q[$];
        int errors;

        function new();
            timeout_ms  = 16'd2000;
            inactive_ms = 23'd5400000;
            retry_max   = 3'd3;
            echo_on     = 1'b1;
            stage_q     = STG_PROBE;
            retries_q   = 3'd3;
            elapsed_q   = '0;
            reply_cnt_q = '0;
            reply_ok_q  = 1'b1;
            newline_q   = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [22:0] value);
            case (idx)
                REG_TIMEOUT:  timeout_ms  = value[15:0];
                REG_INACTIVE: inactive_ms = value;
                REG_RETRY:    retry_max   = value[2:0];
                REG_ECHO:     echo_on     = value[0];
                default:      ;
            endcase
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        // work out the result beats of one accepted input beat
        function void note_input(logic [1:0] cmd, logic [7:0] data);
            modem_result_t batch[$];
            modem_result_t r;
            logic [7:0]    chars[$];
            logic [7:0]    want_c;
            logic [3:0]    st;
            logic [1:0]    status;
            string         txt;
            int            i;
            st = stage_q;
            r = '0;
            case (cmd)
                CMD_START: begin
                    stage_q = STG_PROBE;
                    retries_q = retry_max;
                    batch.push_back(r);
                end
                CMD_RX: begin
                    if (st == STG_RXWAIT) begin
                        // receive mode: pass through and restart the quiet count
                        elapsed_q = '0;
                        r.console_valid = 1'b1;
                        r.console_byte = data;
                    end else if (awaits_reply(st) && !newline_q) begin
                        txt = reply_text(slot_for(st));
                        if (reply_cnt_q < txt.len()) begin
                            want_c = txt[reply_cnt_q];
                            if (want_c != data)
                                reply_ok_q = 1'b0;
                            reply_cnt_q++;
                        end
                        if (data == CHAR_LF)
                            newline_q = 1'b1;
                        r.console_valid = echo_on;
                        r.console_byte = echo_on ? data : 8'h00;
                    end
                    batch.push_back(r);
                end
                CMD_TICK: begin
                    if (elapsed_q != ELAPSED_MAX)
                        elapsed_q++;
                    if (sends_text(st)) begin
                        txt = command_body(slot_for(st));
                        for (i = 0; i < txt.len(); i++)
                            chars.push_back(txt[i]);
                        chars.push_back(CHAR_CR);
                        chars.push_back(CHAR_LF);
                        foreach (chars[k]) begin
                            r.modem_valid = 1'b1;
                            r.modem_byte = chars[k];
                            r.console_valid = echo_on;
                            r.console_byte = echo_on ? chars[k] : 8'h00;
                            batch.push_back(r);
                        end
                        elapsed_q = '0;
                        reply_cnt_q = '0;
                        reply_ok_q = 1'b1;
                        newline_q = 1'b0;
                        stage_q = st + 4'd1;
                    end else if (awaits_reply(st)) begin
                        txt = reply_text(slot_for(st));
                        if (!newline_q && elapsed_q < timeout_ms)
                            status = RS_NONE;
                        else if (!newline_q)
                            status = RS_TIMEOUT;
                        else if (reply_cnt_q != txt.len() || !reply_ok_q)
                            status = RS_ERROR;
                        else
                            status = RS_DONE;
                        if (status == RS_DONE) begin
                            stage_q = after_done(slot_for(st));
                            retries_q = retry_max;
                        end else if (status != RS_NONE) begin
                            // resend while retries remain, else give up
                            if (retries_q != 3'd0) begin
                                stage_q = st - 4'd1;
                                retries_q--;
                            end else begin
                                stage_q = STG_CLEANUP;
                            end
                        end
                        r.reply_status = status;
                        batch.push_back(r);
                    end else begin
                        if (st == STG_RXWAIT && elapsed_q > inactive_ms)
                            stage_q = STG_STOP;
                        else if (st == STG_CLEANUP)
                            stage_q = STG_IDLE;
                        batch.push_back(r);
                    end
                end
                default: batch.push_back(r);
            endcase
            foreach (batch[k]) begin
                batch[k].stage = stage_q;
                batch[k].active = (stage_q != STG_IDLE && stage_q != STG_INVALID);
                batch[k].last = (k == batch.size() - 1);
                expected_q.push_back(batch[k]);
            end
        endfunction

        task cmp_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        // compare one accepted result beat with the oldest expectation
        task check_result(modem_result_t got);
            modem_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing expected: %h", got));
                return;
            end
            want = expected_q.pop_front();
            cmp_field("modem_valid", got.modem_valid, want.modem_valid);
            cmp_field("modem_byte", got.modem_byte, want.modem_byte);
            cmp_field("console_valid", got.console_valid, want.console_valid);
            cmp_field("console_byte", got.console_byte, want.console_byte);
            cmp_field("reply_status", got.reply_status, want.reply_status);
            cmp_field("stage", got.stage, want.stage);
            cmp_field("active", got.active, want.active);
            cmp_field("last", got.last, want.last);
        endtask
    endclass

endpackage

### verif/testbench.sv
// Testbench for at_command_modem_sequencer: directed beats, then random
// command/reply sequences over several register settings, with random idling.
// Depends on amcs_pkg and amcs_tb_pkg (scoreboard and predictor).
module testbench;
    import amcs_pkg::*;
    import amcs_tb_pkg::*;

    localparam int HANG_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 25;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic        result_valid;
    logic        result_stall;
    logic        modem_valid;
    logic [7:0]  modem_byte;
    logic        console_valid;
    logic [7:0]  console_byte;
    logic [1:0]  reply_status;
    logic [3:0]  stage;
    logic        active;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [22:0] cfg_data;

    modem_scoreboard board = new();
    int fed = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;

    at_command_modem_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .rx_byte       (rx_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .modem_valid   (modem_valid),
        .modem_byte    (modem_byte),
        .console_valid (console_valid),
        .console_byte  (console_byte),
        .reply_status  (reply_status),
        .stage         (stage),
        .active        (active),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stall bursts, none once steady
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!steady && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result({modem_valid, modem_byte, console_valid, console_byte,
                                reply_status, stage, active, last});
    end

    // hang detection: too long without any beat moving
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("[at_command_modem_sequencer] ERROR");
            $finish;
        end
    end

    // one input beat; entered and left at a falling edge
    task automatic send_item(logic [1:0] cmd, logic [7:0] data);
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        item_valid <= 1'b1;
        command <= cmd;
        rx_byte <= data;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        board.note_input(cmd, data);
        if (cmd != CMD_NONE)
            fed++;
        @(negedge clk);
    endtask

    task automatic tick();
        send_item(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    // hold the sender until every expected result beat has come
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [22:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // answer the pending command: good, corrupted, short or silent
    task automatic give_reply();
        string      txt;
        logic [7:0] c;
        int         kind;
        int         len;
        int         k;
        int         pos;
        txt = reply_text(slot_for(board.stage_q));
        len = txt.len();
        kind = $urandom_range(0, 99);
        if (kind >= 84 && board.timeout_ms > 20)
            kind = 0;
        // early tick while the reply is still on its way
        if ($urandom_range(0, 9) == 0)
            tick();
        if (kind >= 84)
        begin
            for (k = 0; k < $urandom_range(0, 3); k++)
                send_item(CMD_RX, txt[k]);
            while (awaits_reply(board.stage_q))
                tick();
        end
        else
        begin
            if (kind < 60)
            begin
                for (k = 0; k < len; k++)
                    send_item(CMD_RX, txt[k]);
                // trailing text past the prefix
                if ($urandom_range(0, 1) == 0)
                    send_item(CMD_RX, CHAR_CR);
            end
            else if (kind < 72)
            begin
                pos = $urandom_range(0, len - 1);
                for (k = 0; k < len; k++)
                begin
                    c = txt[k];
                    if (k == pos)
                        c = c ^ 8'($urandom_range(1, 255));
                    send_item(CMD_RX, c);
                end
            end
            else
            begin
                pos = $urandom_range(0, len - 1);
                for (k = 0; k < pos; k++)
                    send_item(CMD_RX, txt[k]);
            end
            send_item(CMD_RX, CHAR_LF);
            // stray byte after the newline
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_RX, 8'($urandom_range(0, 255)));
            tick();
        end
    endtask

    // one random step, chosen from the predicted stage
    task automatic random_step();
        logic [3:0] st;
        int         pick;
        st = board.stage_q;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            wait_drained();
        else if (pick < 8)
            send_item(CMD_NONE, 8'($urandom_range(0, 255)));
        else if (st == STG_IDLE)
            send_item(($urandom_range(0, 4) == 0) ? CMD_TICK : CMD_START,
                      8'($urandom_range(0, 255)));
        else if (st == STG_CLEANUP)
            tick();
        else if (sends_text(st))
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_item(CMD_RX, 8'($urandom_range(0, 255)));
            else if (pick == 1)
                send_item(CMD_START, 8'($urandom_range(0, 255)));
            else
                tick();
        end
        else if (awaits_reply(st))
            give_reply();
        else
        begin
            // receive wait: traffic and ticks; long limits need a start to leave
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(CMD_RX, 8'($urandom_range(0, 255)));
            else if (pick < ((board.inactive_ms > 1000) ? 82 : 97))
                tick();
            else
                send_item(CMD_START, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(logic [15:0] tmo, logic [22:0] quiet_lim,
                             logic [2:0] retries, logic echo);
        int start_count;
        wait_drained();
        write_reg(REG_TIMEOUT, {7'd0, tmo});
        write_reg(REG_INACTIVE, quiet_lim);
        write_reg(REG_RETRY, {20'd0, retries});
        write_reg(REG_ECHO, {22'd0, echo});
        start_count = fed;
        while (fed - start_count < PHASE_ITEMS)
            random_step();
    endtask

    initial
    begin
        string txt;
        int    k;
        item_valid = 1'b0;
        command = CMD_TICK;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_TIMEOUT;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unknown command, dropped byte, short reply, restart,
        // long reply (accepted as good), restart
        send_item(CMD_NONE, 8'hFF);
        send_item(CMD_RX, 8'h00);
        tick();
        send_item(CMD_RX, "+");
        send_item(CMD_RX, "A");
        send_item(CMD_RX, CHAR_LF);
        send_item(CMD_RX, "Q");
        tick();
        send_item(CMD_START, 8'h00);
        tick();
        tick();
        txt = reply_text(SLOT_PROBE);
        for (k = 0; k < txt.len(); k++)
            send_item(CMD_RX, txt[k]);
        send_item(CMD_RX, 8'hFF);
        send_item(CMD_RX, CHAR_LF);
        tick();
        send_item(CMD_START, 8'hFF);

        // random: extremes first, then mid and random settings
        run_phase(16'd65535, 23'd8388607, 3'd7, 1'b1);
        run_phase(16'd1, 23'd1, 3'd0, 1'b0);
        run_phase(16'd4, 23'd6, 3'd2, 1'b1);
        run_phase(16'd3, 23'd3, 3'd1, 1'b0);
        run_phase(16'($urandom_range(2, 12)), 23'($urandom_range(1, 10)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        steady = 1'b1;
        run_phase(16'($urandom_range(2, 12)), 23'($urandom_range(1, 10)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));

        wait_drained();
        repeat (16) @(posedge clk);
        if (board.errors == 0)
            $display("[at_command_modem_sequencer] OK");
        else
            $display("[at_command_modem_sequencer] ERROR");
        $finish;
    end

endmodule

### sim.f
sv/amcs_pkg.sv
sv/amcs_front.sv
sv/amcs_queue.sv
sv/amcs_back.sv
sv/at_command_modem_sequencer.sv
verif/amcs_tb_pkg.sv
verif/testbench.sv
